FILE: hdl/arac_pkg.sv
// arac_pkg: shared constants, codes and controller/datapath types
// for the address region allocator; no dependencies
package arac_pkg;

	localparam int AW     = 48;
	localparam int NODES  = 64;
	localparam int IW     = 6;
	localparam int PW     = 7;
	localparam int PAGE_W = 12;
	localparam logic [PW-1:0] NIL = PW'(NODES);

	typedef enum logic [1:0] {
		MODE_ADD,
		MODE_ALLOC,
		MODE_FREE,
		MODE_FIND
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_FULL,
		ST_NOSPACE,
		ST_BADALIGN
	} status_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_ADD_NODE,
		OP_ADD_LINK,
		OP_READ_CUR,
		OP_SCAN,
		OP_CARVE_S,
		OP_CARVE_P,
		OP_CARVE_N,
		OP_READ_H,
		OP_FLOAD,
		OP_OLOAD,
		OP_ABSORB_P,
		OP_LINK_P,
		OP_READ_NEXT,
		OP_ABSORB_N,
		OP_LINK_N,
		OP_ALIGN1,
		OP_ALIGN2,
		OP_FOUND,
		OP_FIN
	} op_t;

	typedef struct packed {
		op_t     op;
		status_t st;
		logic    piece;
	} cmd_t;

	typedef struct packed {
		logic cur_nil;
		logic full;
		logic hold;
		logic next_nil;
		logic need2;
		logic need_ok;
		logic rd_alloc;
		logic slot_h;
		logic prev_nil;
		logic merge_p;
		logic merge_n;
		logic c_next_nil;
		logic div_done;
		logic align_bad;
		logic size_ovf;
		logic hit;
	} flags_t;

endpackage

FILE: hdl/address_region_allocator_core.sv
// address_region_allocator_core: first-fit region allocator with coalescing
// add appends a node, free merges with free neighbours, allocate scans from the head,
// checks for free slots and carves one or two new nodes when it succeeds
// find checks each free node with the 48-step remainder unit until one fits
// one request at a time: busy is high from acceptance until the cycle done pulses
// reset empties the region list and the slot map; results cannot be stalled
module address_region_allocator_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              mode,
	input  logic [arac_pkg::AW-1:0] addr,
	input  logic [arac_pkg::AW-1:0] size,
	input  logic [arac_pkg::IW-1:0] handle,
	input  logic [arac_pkg::AW-1:0] alignment,
	output logic                    done,
	output logic [1:0]              status,
	output logic [arac_pkg::IW-1:0] result_handle,
	output logic [arac_pkg::AW-1:0] found_addr
);

	arac_pkg::cmd_t   cmd;
	arac_pkg::flags_t flags;

	arac_ctl u_ctl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.flags  (flags),
		.cmd    (cmd),
		.busy   (busy)
	);

	arac_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.addr          (addr),
		.size          (size),
		.handle        (handle),
		.alignment     (alignment),
		.flags         (flags),
		.done          (done),
		.status        (status),
		.result_handle (result_handle),
		.found_addr    (found_addr)
	);

endmodule

FILE: hdl/arac_rem.sv
// arac_rem: bit-serial restoring remainder unit, one quotient bit per cycle
// depends on arac_pkg
module arac_rem (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [arac_pkg::AW-1:0] dividend,
	input  logic [arac_pkg::AW-1:0] divisor,
	output logic                    done,
	output logic [arac_pkg::AW-1:0] rem
);

	localparam int CW = $clog2(arac_pkg::AW);

	logic                    busy_q;
	logic [CW-1:0]           cnt_q;
	logic [arac_pkg::AW-1:0] num_q;
	logic [arac_pkg::AW-1:0] r_q;
	logic [arac_pkg::AW:0]   shifted;
	logic [arac_pkg::AW:0]   diff;
	logic [arac_pkg::AW-1:0] r_nxt;

	always_comb begin
		shifted = {r_q, num_q[arac_pkg::AW-1]};
		diff    = shifted - {1'b0, divisor};
		r_nxt   = diff[arac_pkg::AW] ? shifted[arac_pkg::AW-1:0] : diff[arac_pkg::AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(arac_pkg::AW - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q   <= '0;
			num_q <= dividend;
		end else if (busy_q) begin
			r_q   <= r_nxt;
			num_q <= {num_q[arac_pkg::AW-2:0], 1'b0};
		end
	end

	assign done = !busy_q;
	assign rem  = r_q;

endmodule

FILE: hdl/arac_dp.sv
// arac_dp: node memories, list pointers, slot map and arithmetic of the allocator
// depends on arac_pkg and arac_rem
module arac_dp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  arac_pkg::cmd_t          cmd,
	input  logic [arac_pkg::AW-1:0] addr,
	input  logic [arac_pkg::AW-1:0] size,
	input  logic [arac_pkg::IW-1:0] handle,
	input  logic [arac_pkg::AW-1:0] alignment,
	output arac_pkg::flags_t        flags,
	output logic                    done,
	output logic [1:0]              status,
	output logic [arac_pkg::IW-1:0] result_handle,
	output logic [arac_pkg::AW-1:0] found_addr
);

	localparam int AW = arac_pkg::AW;
	localparam int IW = arac_pkg::IW;
	localparam int PW = arac_pkg::PW;
	localparam int NODES = arac_pkg::NODES;
	localparam int PG = arac_pkg::PAGE_W;
	localparam int CNTW = $clog2(NODES + 1);

	logic [AW-1:0] base_mem [NODES];
	logic [AW-1:0] len_mem  [NODES];
	logic          alloc_mem[NODES];
	logic [PW-1:0] prev_mem [NODES];
	logic [PW-1:0] next_mem [NODES];

	logic [AW-1:0] rd_base, rd_len;
	logic          rd_alloc;
	logic [PW-1:0] rd_prev, rd_next;
	logic [IW-1:0] raddr, raddr_q;

	logic [AW-1:0] addr_q, size_q, align_q, end_q, bytes_q;
	logic [IW-1:0] handle_q;
	logic [PW-1:0] head_q, tail_q, cur_q;
	logic [NODES-1:0] slots_q;
	logic [CNTW-1:0] cnt_q;
	logic [IW-1:0] c_idx_q, o_idx_q, s_q, rh_q;
	logic [AW-1:0] c_base_q, c_len_q, c_top_q, o_base_q, o_len_q, cl_q;
	logic [PW-1:0] c_prev_q, c_next_q, o_prev_q;
	logic [AW-1:0] addv_q, ab_q, room_q, found_q;
	logic          ovf_q, done_q;
	arac_pkg::status_t status_q;

	logic [IW-1:0] fs;
	logic [AW-1:0] cl;
	logic [AW-1:0] rd_top;
	logic [AW:0]   ab_sum;
	logic          div_done;
	logic [AW-1:0] rem;

	logic          we_base, we_len, we_alloc, we_prev, we_next;
	logic [IW-1:0] waddr;
	logic [AW-1:0] w_base, w_len;
	logic          w_alloc;
	logic [PW-1:0] w_prev, w_next;

	arac_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == arac_pkg::OP_SCAN),
		.dividend (rd_base),
		.divisor  (align_q),
		.done     (div_done),
		.rem      (rem)
	);

	always_comb begin
		fs = '0;
		for (int i = NODES - 1; i >= 0; i--)
			if (!slots_q[i])
				fs = IW'(i);
	end

	always_comb begin
		rd_top = rd_base + rd_len;
		cl     = cmd.piece ? size_q : addr_q - c_base_q;
		ab_sum = {1'b0, c_base_q} + {1'b0, addv_q};
	end

	always_comb begin
		case (cmd.op)
			arac_pkg::OP_READ_CUR:  raddr = cur_q[IW-1:0];
			arac_pkg::OP_SCAN:      raddr = rd_next[IW-1:0];
			arac_pkg::OP_READ_H:    raddr = handle_q;
			arac_pkg::OP_FLOAD:     raddr = rd_prev[IW-1:0];
			arac_pkg::OP_READ_NEXT: raddr = c_next_q[IW-1:0];
			default:                raddr = raddr_q;
		endcase
	end

	always_comb begin
		we_base  = 1'b0;
		we_len   = 1'b0;
		we_alloc = 1'b0;
		we_prev  = 1'b0;
		we_next  = 1'b0;
		waddr    = fs;
		w_base   = c_base_q;
		w_len    = c_len_q;
		w_alloc  = 1'b0;
		w_prev   = c_prev_q;
		w_next   = arac_pkg::NIL;
		case (cmd.op)
			arac_pkg::OP_ADD_NODE: begin
				{we_base, we_len, we_alloc, we_prev, we_next} = '1;
				w_base = addr_q;
				w_len  = size_q;
				w_prev = tail_q;
			end
			arac_pkg::OP_ADD_LINK: begin
				we_next = (tail_q != arac_pkg::NIL);
				waddr   = tail_q[IW-1:0];
				w_next  = {1'b0, s_q};
			end
			arac_pkg::OP_CARVE_S: begin
				{we_base, we_len, we_alloc, we_prev, we_next} = '1;
				w_len   = cl;
				w_alloc = cmd.piece;
				w_next  = {1'b0, c_idx_q};
			end
			arac_pkg::OP_CARVE_P: begin
				we_next = (c_prev_q != arac_pkg::NIL);
				waddr   = c_prev_q[IW-1:0];
				w_next  = {1'b0, s_q};
			end
			arac_pkg::OP_CARVE_N: begin
				{we_base, we_len, we_prev} = '1;
				waddr  = c_idx_q;
				w_base = c_base_q + cl_q;
				w_len  = c_len_q - cl_q;
				w_prev = {1'b0, s_q};
			end
			arac_pkg::OP_FLOAD: begin
				we_alloc = 1'b1;
				waddr    = handle_q;
			end
			arac_pkg::OP_ABSORB_P: begin
				{we_base, we_len, we_prev} = '1;
				waddr  = c_idx_q;
				w_base = o_base_q;
				w_len  = c_len_q + o_len_q;
				w_prev = o_prev_q;
			end
			arac_pkg::OP_LINK_P: begin
				we_next = (o_prev_q != arac_pkg::NIL);
				waddr   = o_prev_q[IW-1:0];
				w_next  = {1'b0, c_idx_q};
			end
			arac_pkg::OP_ABSORB_N: begin
				{we_base, we_len, we_prev} = '1;
				waddr  = o_idx_q;
				w_len  = o_len_q + c_len_q;
			end
			arac_pkg::OP_LINK_N: begin
				we_next = (c_prev_q != arac_pkg::NIL);
				waddr   = c_prev_q[IW-1:0];
				w_next  = {1'b0, o_idx_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_base)  base_mem[waddr]  <= w_base;
		if (we_len)   len_mem[waddr]   <= w_len;
		if (we_alloc) alloc_mem[waddr] <= w_alloc;
		if (we_prev)  prev_mem[waddr]  <= w_prev;
		if (we_next)  next_mem[waddr]  <= w_next;
		rd_base  <= base_mem[raddr];
		rd_len   <= len_mem[raddr];
		rd_alloc <= alloc_mem[raddr];
		rd_prev  <= prev_mem[raddr];
		rd_next  <= next_mem[raddr];
		raddr_q  <= raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= arac_pkg::NIL;
			tail_q   <= arac_pkg::NIL;
			slots_q  <= '0;
			cnt_q    <= CNTW'(NODES);
			done_q   <= 1'b0;
			status_q <= arac_pkg::ST_OK;
		end else begin
			done_q <= (cmd.op == arac_pkg::OP_FIN);
			if (cmd.op == arac_pkg::OP_FIN)
				status_q <= cmd.st;
			case (cmd.op)
				arac_pkg::OP_ADD_NODE, arac_pkg::OP_CARVE_S: begin
					slots_q[fs] <= 1'b1;
					cnt_q       <= cnt_q - 1'b1;
				end
				arac_pkg::OP_ADD_LINK: begin
					if (tail_q == arac_pkg::NIL)
						head_q <= {1'b0, s_q};
					tail_q <= {1'b0, s_q};
				end
				arac_pkg::OP_CARVE_P: begin
					if (c_prev_q == arac_pkg::NIL)
						head_q <= {1'b0, s_q};
				end
				arac_pkg::OP_ABSORB_P: begin
					slots_q[o_idx_q] <= 1'b0;
					cnt_q            <= cnt_q + 1'b1;
				end
				arac_pkg::OP_LINK_P: begin
					if (o_prev_q == arac_pkg::NIL)
						head_q <= {1'b0, c_idx_q};
				end
				arac_pkg::OP_ABSORB_N: begin
					slots_q[c_idx_q] <= 1'b0;
					cnt_q            <= cnt_q + 1'b1;
				end
				arac_pkg::OP_LINK_N: begin
					if (c_prev_q == arac_pkg::NIL)
						head_q <= {1'b0, o_idx_q};
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			arac_pkg::OP_LOAD: begin
				addr_q   <= addr;
				size_q   <= size;
				handle_q <= handle;
				align_q  <= alignment;
				end_q    <= addr + size;
				bytes_q  <= (size[PG-1:0] == '0) ? size :
					{size[AW-1:PG] + 1'b1, {PG{1'b0}}};
				cur_q    <= head_q;
				rh_q     <= '0;
				found_q  <= '0;
			end
			arac_pkg::OP_ADD_NODE: s_q <= fs;
			arac_pkg::OP_SCAN: begin
				c_idx_q  <= raddr_q;
				c_base_q <= rd_base;
				c_len_q  <= rd_len;
				c_top_q  <= rd_top;
				c_prev_q <= rd_prev;
				c_next_q <= rd_next;
				cur_q    <= rd_next;
			end
			arac_pkg::OP_CARVE_S: begin
				s_q  <= fs;
				cl_q <= cl;
				if (cmd.piece)
					rh_q <= fs;
			end
			arac_pkg::OP_CARVE_N: begin
				c_base_q <= c_base_q + cl_q;
				c_len_q  <= c_len_q - cl_q;
				c_prev_q <= {1'b0, s_q};
			end
			arac_pkg::OP_FLOAD: begin
				c_idx_q  <= raddr_q;
				c_base_q <= rd_base;
				c_len_q  <= rd_len;
				c_top_q  <= rd_top;
				c_prev_q <= rd_prev;
				c_next_q <= rd_next;
			end
			arac_pkg::OP_OLOAD: begin
				o_idx_q  <= raddr_q;
				o_base_q <= rd_base;
				o_len_q  <= rd_len;
				o_prev_q <= rd_prev;
			end
			arac_pkg::OP_ABSORB_P: begin
				c_base_q <= o_base_q;
				c_len_q  <= c_len_q + o_len_q;
				c_prev_q <= o_prev_q;
			end
			arac_pkg::OP_ALIGN1: addv_q <= (rem == '0) ? '0 : align_q - rem;
			arac_pkg::OP_ALIGN2: begin
				ab_q   <= ab_sum[AW-1:0];
				ovf_q  <= ab_sum[AW];
				room_q <= c_len_q - addv_q;
			end
			arac_pkg::OP_FOUND: found_q <= ab_q;
			default: ;
		endcase
	end

	always_comb begin
		flags.cur_nil    = (cur_q == arac_pkg::NIL);
		flags.full       = (cnt_q == '0);
		flags.hold       = !rd_alloc && (rd_base <= addr_q) && (end_q > addr_q) &&
			(end_q <= rd_top);
		flags.next_nil   = (rd_next == arac_pkg::NIL);
		flags.need2      = (addr_q != c_base_q);
		flags.need_ok    = flags.need2 ? (cnt_q >= CNTW'(2)) : (cnt_q != '0);
		flags.rd_alloc   = rd_alloc;
		flags.slot_h     = slots_q[handle_q];
		flags.prev_nil   = (rd_prev == arac_pkg::NIL);
		flags.merge_p    = !rd_alloc && (rd_top == c_base_q);
		flags.merge_n    = !rd_alloc && (c_top_q == rd_base);
		flags.c_next_nil = (c_next_q == arac_pkg::NIL);
		flags.div_done   = div_done;
		flags.align_bad  = (align_q == '0) || (align_q[PG-1:0] != '0);
		flags.size_ovf   = (size_q[PG-1:0] != '0) && (&size_q[AW-1:PG]);
		flags.hit        = !ovf_q && (c_top_q > ab_q) && (room_q >= bytes_q);
	end

	assign done          = done_q;
	assign status        = status_q;
	assign result_handle = rh_q;
	assign found_addr    = found_q;

endmodule

FILE: hdl/arac_ctl.sv
// arac_ctl: sequencing state machine of the allocator, drives datapath commands
// depends on arac_pkg
module arac_ctl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       mode,
	input  arac_pkg::flags_t flags,
	output arac_pkg::cmd_t   cmd,
	output logic             busy
);

	typedef enum logic [4:0] {
		S_IDLE, S_ADD, S_ADD_LINK,
		S_A_RD, S_A_EV, S_A_CHK, S_A_CS, S_A_CP, S_A_CN,
		S_F0, S_F1, S_F2, S_F3, S_F4, S_F5, S_F6, S_F7, S_F8,
		S_D0, S_D1, S_D2, S_D3, S_D4, S_D5, S_D6,
		S_FIN
	} state_t;

	state_t            state_q, state_d;
	arac_pkg::status_t st_q, st_d;
	logic              piece_q, piece_d;

	always_comb begin
		state_d   = state_q;
		st_d      = st_q;
		piece_d   = piece_q;
		cmd.op    = arac_pkg::OP_NONE;
		cmd.st    = st_q;
		cmd.piece = piece_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op = arac_pkg::OP_LOAD;
					st_d   = arac_pkg::ST_OK;
					case (arac_pkg::mode_t'(mode))
						arac_pkg::MODE_ADD:   state_d = S_ADD;
						arac_pkg::MODE_ALLOC: state_d = S_A_RD;
						arac_pkg::MODE_FREE:  state_d = S_F0;
						default:              state_d = S_D0;
					endcase
				end
			end
			S_ADD: begin
				if (flags.full) begin
					st_d    = arac_pkg::ST_FULL;
					state_d = S_FIN;
				end else begin
					cmd.op  = arac_pkg::OP_ADD_NODE;
					state_d = S_ADD_LINK;
				end
			end
			S_ADD_LINK: begin
				cmd.op  = arac_pkg::OP_ADD_LINK;
				state_d = S_FIN;
			end
			S_A_RD: begin
				if (flags.cur_nil) begin
					st_d    = arac_pkg::ST_NOSPACE;
					state_d = S_FIN;
				end else begin
					cmd.op  = arac_pkg::OP_READ_CUR;
					state_d = S_A_EV;
				end
			end
			S_A_EV: begin
				cmd.op = arac_pkg::OP_SCAN;
				if (flags.hold) begin
					state_d = S_A_CHK;
				end else if (flags.next_nil) begin
					st_d    = arac_pkg::ST_NOSPACE;
					state_d = S_FIN;
				end
			end
			S_A_CHK: begin
				if (!flags.need_ok) begin
					st_d    = arac_pkg::ST_FULL;
					state_d = S_FIN;
				end else begin
					piece_d = !flags.need2;
					state_d = S_A_CS;
				end
			end
			S_A_CS: begin
				cmd.op  = arac_pkg::OP_CARVE_S;
				state_d = S_A_CP;
			end
			S_A_CP: begin
				cmd.op  = arac_pkg::OP_CARVE_P;
				state_d = S_A_CN;
			end
			S_A_CN: begin
				cmd.op = arac_pkg::OP_CARVE_N;
				if (piece_q) begin
					state_d = S_FIN;
				end else begin
					piece_d = 1'b1;
					state_d = S_A_CS;
				end
			end
			S_F0: begin
				if (flags.slot_h) begin
					cmd.op  = arac_pkg::OP_READ_H;
					state_d = S_F1;
				end else begin
					state_d = S_FIN;
				end
			end
			S_F1: begin
				cmd.op  = arac_pkg::OP_FLOAD;
				state_d = flags.prev_nil ? S_F5 : S_F2;
			end
			S_F2: begin
				cmd.op  = arac_pkg::OP_OLOAD;
				state_d = flags.merge_p ? S_F3 : S_F5;
			end
			S_F3: begin
				cmd.op  = arac_pkg::OP_ABSORB_P;
				state_d = S_F4;
			end
			S_F4: begin
				cmd.op  = arac_pkg::OP_LINK_P;
				state_d = S_F5;
			end
			S_F5: begin
				if (flags.c_next_nil) begin
					state_d = S_FIN;
				end else begin
					cmd.op  = arac_pkg::OP_READ_NEXT;
					state_d = S_F6;
				end
			end
			S_F6: begin
				cmd.op  = arac_pkg::OP_OLOAD;
				state_d = flags.merge_n ? S_F7 : S_FIN;
			end
			S_F7: begin
				cmd.op  = arac_pkg::OP_ABSORB_N;
				state_d = S_F8;
			end
			S_F8: begin
				cmd.op  = arac_pkg::OP_LINK_N;
				state_d = S_FIN;
			end
			S_D0: begin
				if (flags.align_bad) begin
					st_d    = arac_pkg::ST_BADALIGN;
					state_d = S_FIN;
				end else if (flags.size_ovf) begin
					st_d    = arac_pkg::ST_NOSPACE;
					state_d = S_FIN;
				end else begin
					state_d = S_D1;
				end
			end
			S_D1: begin
				if (flags.cur_nil) begin
					st_d    = arac_pkg::ST_NOSPACE;
					state_d = S_FIN;
				end else begin
					cmd.op  = arac_pkg::OP_READ_CUR;
					state_d = S_D2;
				end
			end
			S_D2: begin
				cmd.op  = arac_pkg::OP_SCAN;
				state_d = flags.rd_alloc ? S_D1 : S_D3;
			end
			S_D3: begin
				if (flags.div_done)
					state_d = S_D4;
			end
			S_D4: begin
				cmd.op  = arac_pkg::OP_ALIGN1;
				state_d = S_D5;
			end
			S_D5: begin
				cmd.op  = arac_pkg::OP_ALIGN2;
				state_d = S_D6;
			end
			S_D6: begin
				if (flags.hit) begin
					cmd.op  = arac_pkg::OP_FOUND;
					state_d = S_FIN;
				end else begin
					state_d = S_D1;
				end
			end
			S_FIN: begin
				cmd.op  = arac_pkg::OP_FIN;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= arac_pkg::ST_OK;
			piece_q <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			piece_q <= piece_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

FILE: hdl/arac_chk.sv
// arac_chk: port-level checks of the allocator request/result sequencing
// depends on arac_pkg; bound to address_region_allocator_core
module arac_chk (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic                    done,
	input logic [1:0]              status,
	input logic [arac_pkg::IW-1:0] result_handle,
	input logic [arac_pkg::AW-1:0] found_addr
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) && !busy)
		else $error("done without a request in flight");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != arac_pkg::ST_OK |-> result_handle == '0 && found_addr == '0)
		else $error("failed request returned a handle or address");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("more than one result for a request");

endmodule

bind address_region_allocator_core arac_chk u_arac_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.status        (status),
	.result_handle (result_handle),
	.found_addr    (found_addr)
);

FILE: tb/address_region_allocator_core_tb.sv
// address_region_allocator_core_tb: directed table then random requests, checked against the table
// or an in-bench model of the region list; depends on arac_pkg and address_region_allocator_core
module address_region_allocator_core_tb;
	import arac_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint CYCLE_LIMIT = 20000000;
	localparam int N_RANDOM = 1700;
	localparam logic [AW-1:0] PAGE = AW'(4096);
	localparam logic [AW-1:0] ONES = '1;

	typedef struct {
		mode_t          m;
		logic [AW-1:0]  a;
		logic [AW-1:0]  s;
		logic [IW-1:0]  h;
		logic [AW-1:0]  al;
		bit             chk;
		status_t        st;
		logic [IW-1:0]  rh;
		logic [AW-1:0]  fa;
	} row_t;

	typedef struct {
		status_t        st;
		logic [IW-1:0]  rh;
		logic [AW-1:0]  fa;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] mode = '0;
	logic [AW-1:0] addr = '0;
	logic [AW-1:0] size = '0;
	logic [IW-1:0] handle = '0;
	logic [AW-1:0] alignment = '0;
	logic done;
	logic [1:0] status;
	logic [IW-1:0] result_handle;
	logic [AW-1:0] found_addr;

	logic [AW-1:0] reg_base [NODES];
	logic [AW-1:0] reg_len [NODES];
	bit            reg_taken [NODES];
	logic [PW-1:0] reg_prev [NODES];
	logic [PW-1:0] reg_next [NODES];
	bit            slot_used [NODES];
	logic [PW-1:0] list_first = NIL;
	logic [PW-1:0] list_last = NIL;

	outcome_t pending_results [$];
	int mismatches = 0;
	longint cycles = 0;
	logic [AW-1:0] next_base = AW'(48'h10_0000);
	bit quiet = 1'b0;

	address_region_allocator_core u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode), .addr(addr),
		.size(size), .handle(handle), .alignment(alignment), .done(done), .status(status),
		.result_handle(result_handle), .found_addr(found_addr)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycles, what);
		mismatches++;
	endtask

	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				e = pending_results.pop_front();
				if (status !== e.st)
					report_mismatch($sformatf("status %0d expected %0d", status, e.st));
				if (result_handle !== e.rh)
					report_mismatch($sformatf("handle %0d expected %0d", result_handle, e.rh));
				if (found_addr !== e.fa)
					report_mismatch($sformatf("found %h expected %h", found_addr, e.fa));
			end
		end
	end

	function automatic logic [PW-1:0] claim_slot();
		for (int i = 0; i < NODES; i++)
			if (!slot_used[i]) begin
				slot_used[i] = 1'b1;
				return PW'(i);
			end
		return NIL;
	endfunction

	function automatic int free_slot_count();
		int c = 0;
		for (int i = 0; i < NODES; i++)
			if (!slot_used[i]) c++;
		return c;
	endfunction

	function automatic logic [PW-1:0] split_front(logic [PW-1:0] n, logic [AW-1:0] len);
		logic [PW-1:0] s;
		logic [PW-1:0] p;
		s = claim_slot();
		p = reg_prev[n];
		reg_base[s] = reg_base[n];
		reg_len[s] = len;
		reg_taken[s] = 1'b0;
		reg_base[n] = reg_base[n] + len;
		reg_len[n] = reg_len[n] - len;
		reg_prev[s] = p;
		if (p != NIL) reg_next[p] = s; else list_first = s;
		reg_next[s] = n;
		reg_prev[n] = s;
		return s;
	endfunction

	function automatic void merge_prev_into(logic [PW-1:0] n);
		logic [PW-1:0] p;
		logic [PW-1:0] pp;
		logic [PW-1:0] pn;
		p = reg_prev[n];
		reg_base[n] = reg_base[p];
		reg_len[n] = reg_len[n] + reg_len[p];
		pp = reg_prev[p];
		pn = reg_next[p];
		if (pp != NIL) reg_next[pp] = pn; else list_first = pn;
		if (pn != NIL) reg_prev[pn] = pp; else list_last = pp;
		reg_prev[p] = NIL;
		reg_next[p] = NIL;
		slot_used[p] = 1'b0;
	endfunction

	function automatic bit mergeable(logic [PW-1:0] p, logic [PW-1:0] n);
		logic [AW-1:0] e;
		if (p == NIL || n == NIL) return 1'b0;
		e = reg_base[p] + reg_len[p];
		return !reg_taken[p] && !reg_taken[n] && e == reg_base[n];
	endfunction

	function automatic bit covers(logic [PW-1:0] n, logic [AW-1:0] a, logic [AW-1:0] s);
		logic [AW-1:0] e;
		logic [AW-1:0] top;
		e = a + s;
		top = reg_base[n] + reg_len[n];
		return !reg_taken[n] && reg_base[n] <= a && e > a && e <= top;
	endfunction

	function automatic bit round_to(logic [AW-1:0] v, logic [AW-1:0] m, output logic [AW-1:0] r);
		logic [AW-1:0] rem;
		logic [AW-1:0] inc;
		rem = v % m;
		r = v;
		if (rem == 0) return 1'b1;
		inc = m - rem;
		if (v > ONES - inc) return 1'b0;
		r = v + inc;
		return 1'b1;
	endfunction

	function automatic outcome_t predict_region_op(mode_t m, logic [AW-1:0] a, logic [AW-1:0] s,
			logic [IW-1:0] h, logic [AW-1:0] al);
		outcome_t o;
		logic [PW-1:0] cur;
		logic [PW-1:0] sl;
		logic [PW-1:0] piece;
		logic [AW-1:0] bytes;
		logic [AW-1:0] ab;
		logic [AW-1:0] top;
		logic [AW-1:0] room;
		int steps;
		int need;
		bit hit;
		o.st = ST_OK;
		o.rh = '0;
		o.fa = '0;
		case (m)
			MODE_ADD: begin
				sl = claim_slot();
				if (sl == NIL) begin
					o.st = ST_FULL;
				end else begin
					reg_base[sl] = a;
					reg_len[sl] = s;
					reg_taken[sl] = 1'b0;
					reg_next[sl] = NIL;
					reg_prev[sl] = list_last;
					if (list_last != NIL) reg_next[list_last] = sl; else list_first = sl;
					list_last = sl;
				end
			end
			MODE_ALLOC: begin
				cur = list_first;
				steps = 0;
				while (cur != NIL && steps < NODES && !covers(cur, a, s)) begin
					cur = reg_next[cur];
					steps++;
				end
				if (cur == NIL || steps >= NODES) begin
					o.st = ST_NOSPACE;
				end else begin
					need = (a == reg_base[cur]) ? 1 : 2;
					if (free_slot_count() < need) begin
						o.st = ST_FULL;
					end else begin
						if (need == 2) void'(split_front(cur, a - reg_base[cur]));
						piece = split_front(cur, s);
						reg_taken[piece] = 1'b1;
						o.rh = IW'(piece);
					end
				end
			end
			MODE_FREE: begin
				if (slot_used[h]) begin
					reg_taken[h] = 1'b0;
					if (mergeable(reg_prev[h], PW'(h))) merge_prev_into(PW'(h));
					if (mergeable(PW'(h), reg_next[h])) merge_prev_into(reg_next[h]);
				end
			end
			default: begin
				if (al == 0 || (al % PAGE) != 0) begin
					o.st = ST_BADALIGN;
				end else if (!round_to(s, PAGE, bytes)) begin
					o.st = ST_NOSPACE;
				end else begin
					hit = 1'b0;
					cur = list_first;
					steps = 0;
					while (cur != NIL && steps < NODES && !hit) begin
						if (!reg_taken[cur] && round_to(reg_base[cur], al, ab)) begin
							top = reg_base[cur] + reg_len[cur];
							room = reg_len[cur] - (ab - reg_base[cur]);
							if (top > ab && room >= bytes) begin
								o.fa = ab;
								hit = 1'b1;
							end
						end
						cur = reg_next[cur];
						steps++;
					end
					if (!hit) o.st = ST_NOSPACE;
				end
			end
		endcase
		return o;
	endfunction

	task automatic issue_request(input row_t r);
		outcome_t o;
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		mode <= r.m;
		addr <= r.a;
		size <= r.s;
		handle <= r.h;
		alignment <= r.al;
		do @(posedge clk); while (busy);
		o = predict_region_op(r.m, r.a, r.s, r.h, r.al);
		if (r.chk) begin
			o.st = r.st;
			o.rh = r.rh;
			o.fa = r.fa;
		end
		pending_results.push_back(o);
		@(negedge clk);
	endtask

	function automatic logic [AW-1:0] rand_word();
		return AW'({$urandom, $urandom});
	endfunction

	function automatic row_t random_request();
		row_t r;
		logic [PW-1:0] pick;
		logic [PW-1:0] cur;
		logic [AW-1:0] off;
		int k;
		int roll;
		r.chk = 1'b0;
		r.st = ST_OK;
		r.rh = '0;
		r.fa = '0;
		r.a = rand_word();
		r.s = rand_word();
		r.h = IW'($urandom);
		r.al = rand_word();
		roll = $urandom_range(0, 99);
		if (roll < 12) begin
			r.m = MODE_ADD;
			if ($urandom_range(0, 5) != 0) begin
				r.a = next_base;
				r.s = PAGE * AW'($urandom_range(1, 16));
				if ($urandom_range(0, 5) == 0) r.s = r.s + AW'($urandom_range(1, 4095));
				next_base = r.a + r.s;
			end
		end else if (roll < 50) begin
			r.m = MODE_ALLOC;
			pick = NIL;
			k = 0;
			cur = list_first;
			while (cur != NIL) begin
				if (!reg_taken[cur] && reg_len[cur] != 0) begin
					k++;
					if ($urandom_range(1, k) == 1) pick = cur;
				end
				cur = reg_next[cur];
			end
			if (pick != NIL && $urandom_range(0, 9) != 0) begin
				off = $urandom_range(0, 1) ? '0 : rand_word() % reg_len[pick];
				if ($urandom_range(0, 1)) off = off & ~(PAGE - 1);
				r.a = reg_base[pick] + off;
				r.s = AW'(1) + rand_word() % (reg_len[pick] - off);
				if ($urandom_range(0, 2) == 0 && r.s > PAGE) r.s = r.s & ~(PAGE - 1);
			end
		end else if (roll < 78) begin
			r.m = MODE_FREE;
			if ($urandom_range(0, 7) != 0) begin
				k = 0;
				for (int i = 0; i < NODES; i++)
					if (slot_used[i] && reg_taken[i]) begin
						k++;
						if ($urandom_range(1, k) == 1) r.h = IW'(i);
					end
			end
		end else begin
			r.m = MODE_FIND;
			if ($urandom_range(0, 7) != 0) r.al = PAGE << $urandom_range(0, 5);
			if ($urandom_range(0, 5) != 0) r.s = AW'($urandom_range(0, 32'h2_0000));
		end
		return r;
	endfunction

	row_t directed_rows [23] = '{
		'{MODE_FIND,  48'h0, 48'h1000, 6'd0, 48'h0, 1, ST_BADALIGN, 6'd0, 48'h0},
		'{MODE_FIND,  48'h0, 48'h0, 6'd0, 48'h1000, 1, ST_NOSPACE, 6'd0, 48'h0},
		'{MODE_ALLOC, 48'h1000, 48'h1000, 6'd0, 48'h0, 1, ST_NOSPACE, 6'd0, 48'h0},
		'{MODE_FREE,  48'h0, 48'h0, 6'd5, 48'h0, 1, ST_OK, 6'd0, 48'h0},
		'{MODE_ADD,   48'h1000, 48'h1_0000, 6'd0, 48'h0, 1, ST_OK, 6'd0, 48'h0},
		'{MODE_ALLOC, 48'h1000, 48'h1000, 6'd0, 48'h0, 1, ST_OK, 6'd1, 48'h0},
		'{MODE_ALLOC, 48'h4000, 48'h2000, 6'd0, 48'h0, 1, ST_OK, 6'd3, 48'h0},
		'{MODE_ALLOC, 48'h8000, 48'h0, 6'd0, 48'h0, 1, ST_NOSPACE, 6'd0, 48'h0},
		'{MODE_ALLOC, 48'hFFFF_FFFF_FFFF, 48'h2, 6'd0, 48'h0, 1, ST_NOSPACE, 6'd0, 48'h0},
		'{MODE_FIND,  48'h0, 48'h1000, 6'd0, 48'h1800, 1, ST_BADALIGN, 6'd0, 48'h0},
		'{MODE_FIND,  48'h0, 48'hFFFF_FFFF_FFFF, 6'd0, 48'h1000, 1, ST_NOSPACE, 6'd0, 48'h0},
		'{MODE_FIND,  48'h0, 48'h1000, 6'd0, 48'h1000, 0, ST_OK, 6'd0, 48'h0},
		'{MODE_FREE,  48'h0, 48'h0, 6'd3, 48'h0, 0, ST_OK, 6'd0, 48'h0},
		'{MODE_FREE,  48'h0, 48'h0, 6'd1, 48'h0, 0, ST_OK, 6'd0, 48'h0},
		'{MODE_FREE,  48'h0, 48'h0, 6'd1, 48'h0, 0, ST_OK, 6'd0, 48'h0},
		'{MODE_FREE,  48'h0, 48'h0, 6'd63, 48'h0, 0, ST_OK, 6'd0, 48'h0},
		'{MODE_ADD,   48'hFFFF_FFFF_F000, 48'h1000, 6'd0, 48'h0, 0, ST_OK, 6'd0, 48'h0},
		'{MODE_ADD,   48'h0, 48'h0, 6'd0, 48'h0, 0, ST_OK, 6'd0, 48'h0},
		'{MODE_ADD,   48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 6'd63, 48'h0, 0, ST_OK, 6'd0, 48'h0},
		'{MODE_FIND,  48'h0, 48'h0, 6'd0, 48'h8000_0000_0000, 0, ST_OK, 6'd0, 48'h0},
		'{MODE_FIND,  48'h0, 48'h1000, 6'd0, 48'hFFFF_FFFF_F000, 0, ST_OK, 6'd0, 48'h0},
		'{MODE_ALLOC, 48'hFFFF_FFFF_F000, 48'h1000, 6'd0, 48'h0, 0, ST_OK, 6'd0, 48'h0},
		'{MODE_ALLOC, 48'h9000, 48'h8000, 6'd0, 48'h0, 0, ST_OK, 6'd0, 48'h0}
	};

	initial begin
		for (int i = 0; i < NODES; i++) begin
			slot_used[i] = 1'b0;
			reg_taken[i] = 1'b0;
			reg_prev[i] = NIL;
			reg_next[i] = NIL;
			reg_base[i] = '0;
			reg_len[i] = '0;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (directed_rows[i]) issue_request(directed_rows[i]);
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
			issue_request(random_request());
		end
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

FILE: filelist.f
hdl/arac_pkg.sv
hdl/arac_rem.sv
hdl/arac_dp.sv
hdl/arac_ctl.sv
hdl/address_region_allocator_core.sv
hdl/arac_chk.sv
tb/address_region_allocator_core_tb.sv
